// ===== rtl/core/fifo_handoff_mutex_top_defines.svh =====
// Assertion macros shared by the mutex RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef FIFO_HANDOFF_MUTEX_TOP_DEFINES_SVH
`define FIFO_HANDOFF_MUTEX_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FHM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fhm_pkg.sv =====
// Package for the handoff mutex: defaults, status codes, control structs.
// No dependencies.
`default_nettype none

package fhm_pkg;

    localparam int DEF_MAX_WAITERS = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int DEF_LEVEL_BITS  = 8;
    localparam int STATUS_W        = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_HANDOFF  = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    // control -> ring
    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    // ring -> control
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fhm_ring.sv =====
// FIFO ring of waiting thread ids with head/tail pointers and a fill count.
// Depends on fhm_pkg and fifo_handoff_mutex_top_defines.svh.
`default_nettype none

`include "fifo_handoff_mutex_top_defines.svh"

module fhm_ring #(
    parameter int MAX_WAITERS = fhm_pkg::DEF_MAX_WAITERS,
    parameter int ID_BITS     = fhm_pkg::DEF_ID_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fhm_pkg::ring_cmd_t     cmd,
    input  logic [ID_BITS-1:0]     push_id,
    output fhm_pkg::ring_stat_t    stat,
    output logic [ID_BITS-1:0]     head_id
);
    import fhm_pkg::*;

    localparam int PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);

    logic [ID_BITS-1:0] ring_mem [MAX_WAITERS];
    logic [ID_BITS-1:0] head_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next  = (head_reg == PTR_W'(MAX_WAITERS - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.push)
        begin
            tail_next  = (tail_reg == PTR_W'(MAX_WAITERS - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // ring store; head entry read ahead at the next head, write-through when the
    // slot being filled becomes the head (push into an empty ring, or push with pop on a one-entry ring)
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[tail_reg] <= push_id;
        end
        if (cmd.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_id;
        end
        else
        begin
            head_data_reg <= ring_mem[head_next];
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(MAX_WAITERS));
    assign head_id    = head_data_reg;

    `FHM_ASSERT_NOW(a_no_pop_empty, cmd.pop, !stat.empty, "pop from empty ring")
    `FHM_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full, "push into full ring")
    `FHM_ASSERT_NEXT(a_push_count, cmd.push, count_reg == $past(count_reg) + 1'b1,
        "fill count did not follow push")

endmodule

`default_nettype wire

// ===== rtl/core/fifo_handoff_mutex_top.sv =====
// Handoff mutex with priority inheritance: request register, decision logic,
// result register. Depends on fhm_pkg, fhm_ring and the assertion header.
//
//  channel   handshake                ports
//  -------   ----------------------   ---------------------------------------
//  request   start & !busy            func, requester_id, requester_level
//  result    done (one-cycle strobe)  status, boost_valid, boost_target,
//                                     boost_level, restore_valid, wake_valid,
//                                     wake_id, owner_now
//
// One request per clock: busy is never raised, so start may stay high.
// Each result passes from the request register through the decision and ring
// update into the result register; the ring's head read is registered and
// feeds the decision logic directly.
// Reset clears ownership, pointers and fill count at once; the id ring is not
// cleared, so there is no start-up sweep. The receiver cannot stall: every
// result is shown for exactly one cycle with done high.
`default_nettype none

`include "fifo_handoff_mutex_top_defines.svh"

module fifo_handoff_mutex_top #(
    parameter int MAX_WAITERS = fhm_pkg::DEF_MAX_WAITERS,
    parameter int ID_BITS     = fhm_pkg::DEF_ID_BITS,
    parameter int LEVEL_BITS  = fhm_pkg::DEF_LEVEL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [ID_BITS-1:0]            requester_id,
    input  logic [LEVEL_BITS-1:0]         requester_level,
    // result
    output logic                          done,
    output logic [fhm_pkg::STATUS_W-1:0]  status,
    output logic                          boost_valid,
    output logic [ID_BITS-1:0]            boost_target,
    output logic [LEVEL_BITS-1:0]         boost_level,
    output logic                          restore_valid,
    output logic                          wake_valid,
    output logic [ID_BITS-1:0]            wake_id,
    output logic [ID_BITS-1:0]            owner_now
);
    import fhm_pkg::*;

    localparam logic [ID_BITS-1:0] NO_OWNER = '1;

    // request register
    logic                  in_valid_reg;
    logic                  func_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [LEVEL_BITS-1:0] level_reg;

    // mutex state
    logic               held_reg, held_next;
    logic [ID_BITS-1:0] owner_reg, owner_next;

    // result register
    logic                  done_reg;
    status_t               status_reg, status_next;
    logic                  boost_valid_reg, boost_valid_next;
    logic [ID_BITS-1:0]    boost_target_reg, boost_target_next;
    logic [LEVEL_BITS-1:0] boost_level_reg, boost_level_next;
    logic                  restore_valid_reg, restore_valid_next;
    logic                  wake_valid_reg, wake_valid_next;
    logic [ID_BITS-1:0]    wake_id_reg, wake_id_next;
    logic [ID_BITS-1:0]    owner_now_reg;

    ring_cmd_t          ring_cmd;
    ring_stat_t         ring_stat;
    logic [ID_BITS-1:0] head_id;

    logic accept;

    assign busy   = 1'b0;          // a request is taken whenever start is high
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            id_reg    <= requester_id;
            level_reg <= requester_level;
        end
    end

    // decision for the registered request
    always_comb
    begin
        held_next          = held_reg;
        owner_next         = owner_reg;
        ring_cmd.push      = 1'b0;
        ring_cmd.pop       = 1'b0;
        status_next        = ST_IGNORED;
        boost_valid_next   = 1'b0;
        boost_target_next  = '0;
        boost_level_next   = '0;
        restore_valid_next = 1'b0;
        wake_valid_next    = 1'b0;
        wake_id_next       = '0;
        if (in_valid_reg && (id_reg != NO_OWNER))
        begin
            if (!func_reg)
            begin
                if (!held_reg)
                begin
                    held_next   = 1'b1;
                    owner_next  = id_reg;
                    status_next = ST_GRANTED;
                end
                else if (ring_stat.full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // owner inherits the waiter's level (also when it waits on itself)
                    ring_cmd.push     = 1'b1;
                    boost_valid_next  = 1'b1;
                    boost_target_next = owner_reg;
                    boost_level_next  = level_reg;
                    status_next       = ST_QUEUED;
                end
            end
            else if (held_reg && (owner_reg == id_reg))
            begin
                restore_valid_next = 1'b1;
                if (!ring_stat.empty)
                begin
                    // straight handoff to the oldest waiter
                    ring_cmd.pop    = 1'b1;
                    owner_next      = head_id;
                    wake_valid_next = 1'b1;
                    wake_id_next    = head_id;
                    status_next     = ST_HANDOFF;
                end
                else
                begin
                    held_next   = 1'b0;
                    owner_next  = NO_OWNER;
                    status_next = ST_RELEASED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            owner_reg <= NO_OWNER;
            done_reg  <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            done_reg  <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            status_reg        <= status_next;
            boost_valid_reg   <= boost_valid_next;
            boost_target_reg  <= boost_target_next;
            boost_level_reg   <= boost_level_next;
            restore_valid_reg <= restore_valid_next;
            wake_valid_reg    <= wake_valid_next;
            wake_id_reg       <= wake_id_next;
            owner_now_reg     <= owner_next;   // NO_OWNER whenever free
        end
    end

    fhm_ring #(
        .MAX_WAITERS (MAX_WAITERS),
        .ID_BITS     (ID_BITS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .push_id (id_reg),
        .stat    (ring_stat),
        .head_id (head_id)
    );

    assign done          = done_reg;
    assign status        = status_reg;
    assign boost_valid   = boost_valid_reg;
    assign boost_target  = boost_target_reg;
    assign boost_level   = boost_level_reg;
    assign restore_valid = restore_valid_reg;
    assign wake_valid    = wake_valid_reg;
    assign wake_id       = wake_id_reg;
    assign owner_now     = owner_now_reg;

    `FHM_ASSERT_NEXT(a_req_to_result, in_valid_reg, done_reg, "request produced no result")
    `FHM_ASSERT_NOW(a_free_no_owner, !held_reg, owner_reg == NO_OWNER,
        "free mutex still names an owner")
    `FHM_ASSERT_NOW(a_wait_needs_owner, !ring_stat.empty, held_reg,
        "waiters queued on a free mutex")

endmodule

`default_nettype wire
